// ----- design/sbpf_pkg.sv -----
`timescale 1ns / 1ps

package sbpf_pkg;

	// Sequencer states of the framer.
	typedef enum logic {
		ST_IDLE,
		ST_SEND
	} sbpf_state_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_ID_FIRST  = 3'd0,
		CFG_ID_SECOND = 3'd1,
		CFG_ID_THIRD  = 3'd2,
		CFG_ID_FOURTH = 3'd3,
		CFG_ID_FIFTH  = 3'd4
	} sbpf_cfg_idx_t;

	localparam int unsigned NUM_IDS = 5;

	// Reset values of the polled servo ids.
	localparam logic [7:0] ID_FIRST_RST  = 8'd3;
	localparam logic [7:0] ID_SECOND_RST = 8'd4;
	localparam logic [7:0] ID_THIRD_RST  = 8'd5;
	localparam logic [7:0] ID_FOURTH_RST = 8'd6;
	localparam logic [7:0] ID_FIFTH_RST  = 8'd7;

	// Packet constants.
	localparam logic [15:0] CRC_POLY     = 16'h8005;
	localparam logic [7:0]  HDR_FF       = 8'hFF;
	localparam logic [7:0]  HDR_FD       = 8'hFD;
	localparam logic [7:0]  HDR_RSV      = 8'h00;
	localparam logic [7:0]  ID_BROADCAST = 8'hFE;
	localparam logic [7:0]  LEN_WRITE    = 8'h09;
	localparam logic [7:0]  LEN_SYNC     = 8'h0C;
	localparam logic [7:0]  LEN_HIGH     = 8'h00;
	localparam logic [7:0]  INST_WRITE   = 8'h03;
	localparam logic [7:0]  INST_SYNC_RD = 8'h82;

	// Request types.
	localparam logic REQ_WRITE   = 1'b0;
	localparam logic REQ_SYNC_RD = 1'b1;

	// Packet lengths in bytes, including the two CRC bytes.
	localparam logic [4:0] WRITE_PKT_LEN = 5'd16;
	localparam logic [4:0] SYNC_PKT_LEN  = 5'd19;

endpackage

// ----- design/sbpf_req_if.sv -----
`timescale 1ns / 1ps

// Transmit request channel.
interface sbpf_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  device_id;
	logic [15:0] ctrl_addr;
	logic [31:0] write_value;
	logic [15:0] read_count;

	modport source (
		output valid, req_type, device_id, ctrl_addr, write_value, read_count,
		input  ready
	);
	modport sink (
		input  valid, req_type, device_id, ctrl_addr, write_value, read_count,
		output ready
	);
endinterface

// ----- design/sbpf_tx_if.sv -----
`timescale 1ns / 1ps

// Packet byte channel.
interface sbpf_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last_byte;

	modport source (
		output valid, tx_byte, last_byte,
		input  ready
	);
	modport sink (
		input  valid, tx_byte, last_byte,
		output ready
	);
endinterface

// ----- design/sbpf_crc_unit.sv -----
`timescale 1ns / 1ps

// Folds one byte into a CRC-16 (MSB first, not reflected).
module sbpf_crc_unit (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);

	// Eight shift steps of the polynomial division.
	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ sbpf_pkg::CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

// ----- design/servo_bus_packet_framer.sv -----
`timescale 1ns / 1ps

// Servo-bus instruction packet framer.
// The req channel takes one transmit request per transaction: a write
// packet (req_type 0) or a sync-read packet (req_type 1). The tx channel
// then carries the packet one byte per transaction, 16 bytes for a write
// and 19 for a sync read, with last_byte set on the final CRC high byte.
// The CRC-16 (polynomial 0x8005, initial value 0) is built by one shared
// byte-wide CRC unit, stepped once per emitted byte ahead of the CRC bytes.
// The first byte is loaded into the output register after a taken request
// has moved the sequencer from idle to its send state. Throughput: one
// byte per cycle while tx is ready, as set by the byte sequencer.
// req.ready is high only between packets; the final byte may still wait in
// the output register while the next request is taken.
// When tx stalls, the byte in the output register holds and the sequencer
// waits. Configuration (cfg_we, cfg_idx, cfg_wdata) sets the five servo ids
// polled by sync read; indexes beyond 4 are ignored.
// Reset (arst_n low) returns the sequencer to idle, empties the output
// register and restores the servo ids to 3, 4, 5, 6 and 7.
module servo_bus_packet_framer (
	input  logic              clk,
	input  logic              arst_n,
	sbpf_req_if.sink          req,
	sbpf_tx_if.source         tx,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_idx,
	input  logic [7:0]        cfg_wdata
);

	sbpf_pkg::sbpf_state_t state_q, state_d;

	logic [7:0]  ids_q [sbpf_pkg::NUM_IDS];
	logic        kind_q;
	logic [7:0]  dev_q;
	logic [15:0] addr_q;
	logic [31:0] val_q;
	logic [15:0] count_q;
	logic [4:0]  idx_q;
	logic [15:0] crc_q;
	logic [15:0] crc_next;
	logic        tx_valid_q;
	logic [7:0]  tx_byte_q;
	logic        tx_last_q;

	logic        req_fire;
	logic        load;
	logic [4:0]  pkt_len;
	logic [7:0]  cur_byte;
	logic        cur_is_crc;
	logic        cur_last;

	assign req_fire = req.valid && req.ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ids_q[0] <= sbpf_pkg::ID_FIRST_RST;
			ids_q[1] <= sbpf_pkg::ID_SECOND_RST;
			ids_q[2] <= sbpf_pkg::ID_THIRD_RST;
			ids_q[3] <= sbpf_pkg::ID_FOURTH_RST;
			ids_q[4] <= sbpf_pkg::ID_FIFTH_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				sbpf_pkg::CFG_ID_FIRST:  ids_q[0] <= cfg_wdata;
				sbpf_pkg::CFG_ID_SECOND: ids_q[1] <= cfg_wdata;
				sbpf_pkg::CFG_ID_THIRD:  ids_q[2] <= cfg_wdata;
				sbpf_pkg::CFG_ID_FOURTH: ids_q[3] <= cfg_wdata;
				sbpf_pkg::CFG_ID_FIFTH:  ids_q[4] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Held request.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_q  <= req.req_type;
			dev_q   <= req.device_id;
			addr_q  <= req.ctrl_addr;
			val_q   <= req.write_value;
			count_q <= req.read_count;
		end
	end

	assign pkt_len = (kind_q == sbpf_pkg::REQ_SYNC_RD) ? sbpf_pkg::SYNC_PKT_LEN
	                                                  : sbpf_pkg::WRITE_PKT_LEN;
	assign cur_is_crc = (idx_q >= pkt_len - 5'd2);
	assign cur_last   = (idx_q == pkt_len - 5'd1);

	// Byte selection for the current packet position.
	always_comb begin
		logic sync;
		sync = (kind_q == sbpf_pkg::REQ_SYNC_RD);
		case (idx_q)
			5'd0, 5'd1: cur_byte = sbpf_pkg::HDR_FF;
			5'd2:  cur_byte = sbpf_pkg::HDR_FD;
			5'd3:  cur_byte = sbpf_pkg::HDR_RSV;
			5'd4:  cur_byte = sync ? sbpf_pkg::ID_BROADCAST : dev_q;
			5'd5:  cur_byte = sync ? sbpf_pkg::LEN_SYNC : sbpf_pkg::LEN_WRITE;
			5'd6:  cur_byte = sbpf_pkg::LEN_HIGH;
			5'd7:  cur_byte = sync ? sbpf_pkg::INST_SYNC_RD : sbpf_pkg::INST_WRITE;
			5'd8:  cur_byte = addr_q[7:0];
			5'd9:  cur_byte = addr_q[15:8];
			5'd10: cur_byte = sync ? count_q[7:0] : val_q[7:0];
			5'd11: cur_byte = sync ? count_q[15:8] : val_q[15:8];
			5'd12: cur_byte = sync ? ids_q[0] : val_q[23:16];
			5'd13: cur_byte = sync ? ids_q[1] : val_q[31:24];
			5'd14: cur_byte = sync ? ids_q[2] : crc_q[7:0];
			5'd15: cur_byte = sync ? ids_q[3] : crc_q[15:8];
			5'd16: cur_byte = ids_q[4];
			5'd17: cur_byte = crc_q[7:0];
			5'd18: cur_byte = crc_q[15:8];
			default: cur_byte = 8'h00;
		endcase
	end

	// Shared CRC unit.
	sbpf_crc_unit u_crc (
		.crc_in  (crc_q),
		.data    (cur_byte),
		.crc_out (crc_next)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sbpf_pkg::ST_IDLE: begin
				if (req_fire) begin
					state_d = sbpf_pkg::ST_SEND;
				end
			end
			sbpf_pkg::ST_SEND: begin
				if (load && cur_last) begin
					state_d = sbpf_pkg::ST_IDLE;
				end
			end
			default: state_d = sbpf_pkg::ST_IDLE;
		endcase
	end

	// Output logic of the sequencer.
	always_comb begin
		req.ready = 1'b0;
		load      = 1'b0;
		case (state_q)
			sbpf_pkg::ST_IDLE: req.ready = 1'b1;
			sbpf_pkg::ST_SEND: load = !tx_valid_q || tx.ready;
			default: ;
		endcase
	end

	// Sequencer state, byte position and running CRC.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbpf_pkg::ST_IDLE;
			idx_q   <= 5'd0;
			crc_q   <= 16'h0000;
		end else begin
			state_q <= state_d;
			if (req_fire) begin
				idx_q <= 5'd0;
				crc_q <= 16'h0000;
			end else if (load) begin
				idx_q <= idx_q + 5'd1;
				if (!cur_is_crc) begin
					crc_q <= crc_next;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid_q <= 1'b0;
		end else if (load) begin
			tx_valid_q <= 1'b1;
		end else if (tx.ready) begin
			tx_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tx_byte_q <= cur_byte;
			tx_last_q <= cur_last;
		end
	end

	assign tx.valid     = tx_valid_q;
	assign tx.tx_byte   = tx_byte_q;
	assign tx.last_byte = tx_last_q;

`ifndef SYNTHESIS
	// A taken request starts a packet from its first byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q == sbpf_pkg::ST_SEND) && (idx_q == 5'd0))
	else $error("request did not start a packet at byte zero");

	// The byte position never runs past the end of the packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbpf_pkg::ST_SEND) |-> (idx_q < pkt_len))
	else $error("byte position beyond packet length");

	// A new request is only taken once every non-final byte has left.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |-> !(tx.valid && !tx.last_byte))
	else $error("request taken while packet bytes are pending");

	// Loading the final byte ends the packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		(load && cur_last) |=> (state_q == sbpf_pkg::ST_IDLE) && tx.last_byte)
	else $error("final byte did not close the packet");
`endif

endmodule

// ----- test/servo_bus_packet_framer_tb.sv -----
`timescale 1ns / 1ps

module servo_bus_packet_framer_tb;
	import sbpf_pkg::*;

	// Bytes of the packet format, kept apart from the design's own constants.
	localparam logic [7:0]  SOF_BYTE      = 8'hFF;
	localparam logic [7:0]  SOF_TAIL      = 8'hFD;
	localparam logic [7:0]  RESERVED_BYTE = 8'h00;
	localparam logic [7:0]  BCAST_ID      = 8'hFE;
	localparam logic [7:0]  WR_LENGTH     = 8'h09;
	localparam logic [7:0]  SR_LENGTH     = 8'h0C;
	localparam logic [7:0]  LENGTH_HI     = 8'h00;
	localparam logic [7:0]  OP_WRITE      = 8'h03;
	localparam logic [7:0]  OP_SYNC_READ  = 8'h82;
	localparam logic [15:0] CRC16_POLY    = 16'h8005;

	localparam int CFG_IDX_COUNT = 8;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 40;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  device_id;
		logic [15:0] ctrl_addr;
		logic [31:0] write_value;
		logic [15:0] read_count;
	} frame_req_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} pkt_byte_t;

	logic clk;
	logic arst_n;
	logic       cfg_we;
	logic [2:0] cfg_idx;
	logic [7:0] cfg_wdata;

	sbpf_req_if req_bus();
	sbpf_tx_if  tx_bus();

	servo_bus_packet_framer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_bus),
		.tx       (tx_bus),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	frame_req_t req_pending[$];
	frame_req_t req_on_bus;
	pkt_byte_t  pkt_bytes_due[$];
	pkt_byte_t  byte_want;
	logic [7:0] servo_id_shadow[NUM_IDS];
	bit         idle_enabled;
	int         req_gap;
	int         tx_stall;
	int         mismatch_count;
	int         cycle_count;

	// Free-running clock with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run limit in case the design hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// Idle length for either side: mostly none, sometimes short, rarely long.
	function automatic int pick_idle();
		int roll;
		roll = $urandom_range(0, 99);
		if (!idle_enabled || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// One byte through the CRC-16, most significant bit first.
	function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] acc;
		acc = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			acc = acc[15] ? ((acc << 1) ^ CRC16_POLY) : (acc << 1);
		return acc;
	endfunction

	// Build the expected packet for one request and queue its bytes.
	function automatic void frame_packet(input frame_req_t r);
		logic [7:0]  body[$];
		logic [15:0] crc;
		pkt_byte_t   pb;
		body.push_back(SOF_BYTE);
		body.push_back(SOF_BYTE);
		body.push_back(SOF_TAIL);
		body.push_back(RESERVED_BYTE);
		if (r.req_type == REQ_WRITE) begin
			body.push_back(r.device_id);
			body.push_back(WR_LENGTH);
			body.push_back(LENGTH_HI);
			body.push_back(OP_WRITE);
			body.push_back(r.ctrl_addr[7:0]);
			body.push_back(r.ctrl_addr[15:8]);
			for (int k = 0; k < 4; k++)
				body.push_back(r.write_value[8*k +: 8]);
		end else begin
			body.push_back(BCAST_ID);
			body.push_back(SR_LENGTH);
			body.push_back(LENGTH_HI);
			body.push_back(OP_SYNC_READ);
			body.push_back(r.ctrl_addr[7:0]);
			body.push_back(r.ctrl_addr[15:8]);
			body.push_back(r.read_count[7:0]);
			body.push_back(r.read_count[15:8]);
			for (int k = 0; k < NUM_IDS; k++)
				body.push_back(servo_id_shadow[k]);
		end
		crc = 16'h0000;
		foreach (body[k]) begin
			crc = crc16_fold(crc, body[k]);
			pb.data = body[k];
			pb.last = 1'b0;
			pkt_bytes_due.push_back(pb);
		end
		// The CRC goes out low byte first and is not folded into itself.
		pb.data = crc[7:0];
		pb.last = 1'b0;
		pkt_bytes_due.push_back(pb);
		pb.data = crc[15:8];
		pb.last = 1'b1;
		pkt_bytes_due.push_back(pb);
	endfunction

	// Request driver: offers queued requests with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid       <= 1'b0;
			req_bus.req_type    <= REQ_WRITE;
			req_bus.device_id   <= '0;
			req_bus.ctrl_addr   <= '0;
			req_bus.write_value <= '0;
			req_bus.read_count  <= '0;
			req_gap = 0;
		end else begin
			// A request transaction completed, so its packet is now due.
			if (req_bus.valid && req_bus.ready)
				frame_packet(req_on_bus);
			// Offer the next request once the channel is free.
			if (!req_bus.valid || req_bus.ready) begin
				if (req_gap > 0) begin
					req_gap--;
					req_bus.valid <= 1'b0;
				end else if (req_pending.size() > 0) begin
					req_on_bus = req_pending.pop_front();
					req_bus.valid       <= 1'b1;
					req_bus.req_type    <= req_on_bus.req_type;
					req_bus.device_id   <= req_on_bus.device_id;
					req_bus.ctrl_addr   <= req_on_bus.ctrl_addr;
					req_bus.write_value <= req_on_bus.write_value;
					req_bus.read_count  <= req_on_bus.read_count;
					req_gap = pick_idle();
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Byte monitor: checks each tx transaction and stalls ready at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_bus.ready <= 1'b0;
			tx_stall = 0;
		end else begin
			if (tx_bus.valid && tx_bus.ready) begin
				if (pkt_bytes_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected byte %02h last_byte %0b",
						tx_bus.tx_byte, tx_bus.last_byte));
				end else begin
					byte_want = pkt_bytes_due.pop_front();
					if (tx_bus.tx_byte !== byte_want.data)
						flag_mismatch($sformatf("tx_byte %02h, expected %02h",
							tx_bus.tx_byte, byte_want.data));
					if (tx_bus.last_byte !== byte_want.last)
						flag_mismatch($sformatf("last_byte %0b, expected %0b on byte %02h",
							tx_bus.last_byte, byte_want.last, byte_want.data));
				end
			end
			if (tx_stall > 0) begin
				tx_stall--;
				tx_bus.ready <= 1'b0;
			end else begin
				tx_bus.ready <= 1'b1;
				tx_stall = pick_idle();
			end
		end
	end

	task automatic queue_request(input logic kind, input logic [7:0] dev,
		input logic [15:0] addr, input logic [31:0] value, input logic [15:0] count);
		frame_req_t r;
		r.req_type    = kind;
		r.device_id   = dev;
		r.ctrl_addr   = addr;
		r.write_value = value;
		r.read_count  = count;
		req_pending.push_back(r);
	endtask

	task automatic queue_random_requests(input int n);
		for (int k = 0; k < n; k++)
			queue_request($urandom_range(0, 1) ? REQ_SYNC_RD : REQ_WRITE,
				8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), $urandom,
				16'($urandom_range(0, 65535)));
	endtask

	// A write is taken at the edge where cfg_we is seen high.
	task automatic write_servo_id(input logic [2:0] idx, input logic [7:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < NUM_IDS)
			servo_id_shadow[idx] = value;
	endtask

	// Block until every request has gone out and every packet byte arrived.
	task automatic wait_for_quiet();
		while (req_pending.size() != 0 || req_bus.valid || pkt_bytes_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_idx             = CFG_ID_FIRST;
		cfg_wdata           = '0;
		req_bus.valid       = 1'b0;
		req_bus.req_type    = REQ_WRITE;
		req_bus.device_id   = '0;
		req_bus.ctrl_addr   = '0;
		req_bus.write_value = '0;
		req_bus.read_count  = '0;
		tx_bus.ready        = 1'b0;
		mismatch_count      = 0;
		cycle_count         = 0;
		idle_enabled        = 1'b1;
		servo_id_shadow[CFG_ID_FIRST]  = ID_FIRST_RST;
		servo_id_shadow[CFG_ID_SECOND] = ID_SECOND_RST;
		servo_id_shadow[CFG_ID_THIRD]  = ID_THIRD_RST;
		servo_id_shadow[CFG_ID_FOURTH] = ID_FOURTH_RST;
		servo_id_shadow[CFG_ID_FIFTH]  = ID_FIFTH_RST;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests with the reset ids: field extremes, the broadcast
		// id and ids above 252 in a write, and fields the packet type ignores.
		queue_request(REQ_WRITE, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000);
		queue_request(REQ_WRITE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		queue_request(REQ_WRITE, BCAST_ID, 16'h0074, 32'h1234_5678, 16'h0000);
		queue_request(REQ_WRITE, BCAST_ID, 16'h0074, 32'h1234_5678, 16'hA5C3);
		queue_request(REQ_WRITE, 8'hFD, 16'h8000, 32'h8000_0001, 16'h5555);
		queue_request(REQ_WRITE, 8'hFC, 16'h0001, 32'h0000_FFFF, 16'h0000);
		queue_request(REQ_WRITE, 8'h55, 16'hAA55, 32'hAA55_AA55, 16'h0000);
		queue_request(REQ_WRITE, 8'hAA, 16'h55AA, 32'h55AA_55AA, 16'hFFFF);
		queue_request(REQ_SYNC_RD, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000);
		queue_request(REQ_SYNC_RD, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		queue_request(REQ_SYNC_RD, 8'h5A, 16'h0084, 32'hDEAD_BEEF, 16'h0004);
		queue_request(REQ_SYNC_RD, 8'h01, 16'h0084, 32'h0000_0000, 16'h0004);
		queue_request(REQ_SYNC_RD, 8'h33, 16'h1234, 32'h0F0F_F0F0, 16'h0100);
		queue_request(REQ_SYNC_RD, 8'hC3, 16'hAA55, 32'h8000_0000, 16'h55AA);
		wait_for_quiet();

		// All ids at zero; writes to the unused indexes must leave them alone.
		for (int i = 0; i < NUM_IDS; i++)
			write_servo_id(i[2:0], 8'h00);
		for (int i = NUM_IDS; i < CFG_IDX_COUNT; i++)
			write_servo_id(i[2:0], 8'hFF);
		for (int k = 0; k < 5; k++)
			queue_request(REQ_SYNC_RD, 8'($urandom_range(0, 255)),
				16'($urandom_range(0, 65535)), $urandom, 16'($urandom_range(0, 65535)));
		queue_random_requests(40);
		wait_for_quiet();

		// Ids at and above the top of the valid range in four slots, sent back to back.
		write_servo_id(CFG_ID_FIRST, 8'hFF);
		write_servo_id(CFG_ID_SECOND, 8'hFE);
		write_servo_id(CFG_ID_THIRD, 8'hFD);
		write_servo_id(CFG_ID_FOURTH, 8'hFC);
		write_servo_id(CFG_ID_FIFTH, 8'hAA);
		idle_enabled = 1'b0;
		queue_random_requests(90);
		wait_for_quiet();

		// Random ids with random idling on both sides.
		idle_enabled = 1'b1;
		for (int p = 0; p < 3; p++) begin
			for (int i = 0; i < NUM_IDS; i++)
				write_servo_id(i[2:0], 8'($urandom_range(0, 255)));
			queue_random_requests(85);
			wait_for_quiet();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
